// File: rtl/core/fed_pkg.sv
// fed_pkg: shared types, widths and saturation helper for the feedback echo delay.
// No dependencies; used by every file in rtl/core.

package fed_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 15;
  localparam int PLAY_W   = 16;

  localparam logic [CFG_W-1:0] MAX_DELAY_RESET = 15'd16384;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry_sample;
    logic signed [SAMPLE_W-1:0] delay_control;
    logic signed [SAMPLE_W-1:0] feedback_control;
    logic signed [SAMPLE_W-1:0] blend_control;
    logic                       all_running;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] output_sample;
    logic                       running;
  } out_item_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [19:0] v);
    logic signed [SAMPLE_W-1:0] res;
    if (v > 20'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/core/feedback_echo_delay.sv
// feedback_echo_delay: top level, control sequencer and sample arithmetic.
// Depends on fed_pkg, fed_ring and fed_rem.

// Each transaction runs through the states S_MIX, S_WR and S_OUT after acceptance: the ring
// read issued at acceptance, then feedback multiply, ring write with wet multiply,
// and sum and saturate into a registered result; the next transaction is taken in
// the cycle after that, and S_OUT waits while the output is stalled. Only one
// transaction at a time goes through the read, modify and write of the ring, so a new
// sample is not taken before the last one's result is registered. After reset a zeroing
// sweep over every ring entry holds in_ready low. A write of max_delay_samples starts
// a reduction of the play position by the new ring length, during which in_ready is also low.

module feedback_echo_delay #(
  parameter int RING_DEPTH = 32768
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fed_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fed_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [fed_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CAP = (RING_DEPTH / 2 < 1) ? 1 : RING_DEPTH / 2;
  localparam logic [fed_pkg::CFG_W-1:0] CAP_M = (CAP > 32767) ? 15'd32767 : 15'(CAP);

  typedef enum logic [1:0] {S_IDLE, S_MIX, S_WR, S_OUT} state_t;

  function automatic logic [fed_pkg::CFG_W-1:0] clamp_m(input logic [fed_pkg::CFG_W-1:0] v);
    logic [fed_pkg::CFG_W-1:0] m;
    m = v;
    if (m == '0) begin
      m = 15'd1;
    end
    if (m > CAP_M) begin
      m = CAP_M;
    end
    return m;
  endfunction

  state_t                      state_r;
  logic [fed_pkg::CFG_W-1:0]   m_r;
  logic [fed_pkg::PLAY_W-1:0]  play_index_r;
  logic                        mod_valid_r;
  logic                        out_valid_r;
  fed_pkg::out_item_t          out_r;

  logic signed [15:0]          x_r;
  logic signed [15:0]          f_r;
  logic signed [15:0]          b_r;
  logic                        run_r;
  logic [fed_pkg::PLAY_W-1:0]  play_r;
  logic [fed_pkg::CFG_W-1:0]   dly_r;
  logic signed [33:0]          dry_prod_r;
  logic signed [15:0]          r_r;
  logic [fed_pkg::PLAY_W-1:0]  rec_r;
  logic signed [33:0]          mix_prod_r;
  logic signed [32:0]          wet_prod_r;

  logic                        clr_busy;
  logic                        rem_busy;
  logic                        rem_done;
  logic [fed_pkg::PLAY_W-1:0]  rem_val;
  logic [15:0]                 rd_data;
  logic [AW-1:0]               rd_addr;

  logic                        accept;
  logic [fed_pkg::PLAY_W-1:0]  play_cur;
  logic [16:0]                 len17;
  logic [15:0]                 wd;
  logic [30:0]                 dly_prod;
  logic signed [17:0]          wdry;
  logic signed [33:0]          dry_prod;
  logic [16:0]                 rec_sum;
  logic [16:0]                 play_inc;
  logic signed [16:0]          mixs;
  logic signed [16:0]          wf;
  logic signed [16:0]          wb;
  logic signed [15:0]          wval;
  logic signed [15:0]          rp;
  logic signed [34:0]          acc_sum;
  logic signed [15:0]          res;
  logic [fed_pkg::CFG_W-1:0]   cfg_m;
  logic                        out_free;

  assign in_ready = (state_r == S_IDLE) && !clr_busy && !rem_busy && !cfg_we;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign cfg_m    = clamp_m(cfg_wdata);

  always_comb begin
    play_cur = mod_valid_r ? rem_val : play_index_r;
    len17    = {1'b0, m_r, 1'b0};
    wd       = {~in_data.delay_control[15], in_data.delay_control[14:0]};
    dly_prod = 31'(wd) * 31'(m_r);
    wdry     = 18'sd32768 - 18'(in_data.blend_control);
    dry_prod = in_data.dry_sample * wdry;
    rec_sum  = 17'(play_r) + 17'(dly_r);
    play_inc = 17'(play_r) + 17'd1;
    mixs     = 17'(signed'(rd_data)) + 17'(x_r);
    wf       = signed'({1'b0, ~f_r[15], f_r[14:0]});
    wb       = signed'({1'b0, ~b_r[15], b_r[14:0]});
    wval     = fed_pkg::sat16(20'(mix_prod_r >>> 16));
    rp       = (rec_r == play_r) ? wval : r_r;
    acc_sum  = 35'(wet_prod_r) + 35'(dry_prod_r);
    res      = fed_pkg::sat16(20'(acc_sum >>> 16));
    rd_addr  = (state_r == S_IDLE) ? AW'(play_cur) : AW'(play_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      m_r          <= clamp_m(fed_pkg::MAX_DELAY_RESET);
      play_index_r <= '0;
      mod_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        m_r         <= cfg_m;
        mod_valid_r <= 1'b0;
      end else if (rem_done) begin
        mod_valid_r <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_MIX;
          end
        end
        S_MIX: begin
          if (run_r) begin
            play_index_r <= (play_inc == len17) ? '0 : play_inc[fed_pkg::PLAY_W-1:0];
            mod_valid_r  <= 1'b0;
          end
          state_r <= S_WR;
        end
        S_WR: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r        <= in_data.dry_sample;
      f_r        <= in_data.feedback_control;
      b_r        <= in_data.blend_control;
      run_r      <= in_data.all_running;
      play_r     <= play_cur;
      dly_r      <= dly_prod[30:16];
      dry_prod_r <= dry_prod;
    end
    if (state_r == S_MIX) begin
      r_r        <= signed'(rd_data);
      rec_r      <= (rec_sum >= len17) ? 16'(rec_sum - len17) : rec_sum[15:0];
      mix_prod_r <= mixs * wf;
    end
    if (state_r == S_WR) begin
      wet_prod_r <= rp * wb;
    end
    if (state_r == S_OUT && out_free) begin
      out_r.output_sample <= run_r ? res : '0;
      out_r.running       <= run_r;
    end
  end

  fed_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    ((state_r == S_WR) && run_r),
    .wr_addr  (AW'(rec_r)),
    .wr_data  (wval),
    .clr_busy (clr_busy)
  );

  fed_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cfg_we),
    .dividend (play_index_r),
    .divisor  ({cfg_m, 1'b0}),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem      (rem_val)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/fed_ring.sv
// fed_ring: echo ring storage, one write and one registered read per cycle.
// Runs a zeroing sweep over every entry after reset. Uses fed_pkg.

module fed_ring #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [AW-1:0]                rd_addr,
  output logic [fed_pkg::SAMPLE_W-1:0] rd_data,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [fed_pkg::SAMPLE_W-1:0] wr_data,
  output logic                         clr_busy
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [fed_pkg::SAMPLE_W-1:0] mem_r [DEPTH];
  logic [fed_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [AW-1:0]                clr_cnt_r;
  logic                         clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == LAST) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem_r[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// File: rtl/core/fed_rem.sv
// fed_rem: restoring remainder unit, one quotient bit per cycle.
// Reduces the play position by a new ring length. Uses fed_pkg.

module fed_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fed_pkg::PLAY_W-1:0] dividend,
  input  logic [fed_pkg::PLAY_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [fed_pkg::PLAY_W-1:0] rem
);

  localparam int CW = $clog2(fed_pkg::PLAY_W);
  localparam logic [CW-1:0] LAST = CW'(fed_pkg::PLAY_W - 1);

  logic [fed_pkg::PLAY_W-1:0] acc_r;
  logic [fed_pkg::PLAY_W-1:0] sh_r;
  logic [fed_pkg::PLAY_W-1:0] div_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [fed_pkg::PLAY_W:0]   trial;
  logic [fed_pkg::PLAY_W-1:0] acc_nxt;

  always_comb begin
    trial = {acc_r, sh_r[fed_pkg::PLAY_W-1]};
    if (trial >= {1'b0, div_r}) begin
      acc_nxt = fed_pkg::PLAY_W'(trial - {1'b0, div_r});
    end else begin
      acc_nxt = trial[fed_pkg::PLAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      sh_r  <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      sh_r  <= {sh_r[fed_pkg::PLAY_W-2:0], 1'b0};
    end
  end

  assign busy = busy_r | done_r;
  assign done = done_r;
  assign rem  = acc_r;

endmodule

// File: rtl/core/fed_checker.sv
// fed_checker: port-level assertions for feedback_echo_delay, with its bind.
// Depends on fed_pkg and the feedback_echo_delay port list.

module fed_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input fed_pkg::out_item_t out_data
);

  // zeroing sweep follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted back to back");

  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.running |-> out_data.output_sample == '0)
    else $error("stopped result carries a nonzero sample");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind feedback_echo_delay fed_checker u_fed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sv/tb_feedback_echo_delay.sv
// tb_feedback_echo_delay: self-checking bench for the feedback echo delay with its own
// echo predictor, a queue-fed driver and a clocked result monitor.
// Depends on fed_pkg and feedback_echo_delay.
`timescale 1ns / 1ps

module tb_feedback_echo_delay;

  localparam int RING_DEPTH = 32768;
  localparam int CYCLE_LIMIT = 600000;
  localparam int STALL_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fed_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fed_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [fed_pkg::CFG_W-1:0] cfg_wdata = '0;

  // predictor state
  bit signed [15:0] echo_mem [RING_DEPTH];
  int unsigned play_pos = 0;
  int unsigned max_delay = 16384;

  int unsigned delay_plan[12] = '{37, 0, 5, 32767, 2, 16384, 1, 255, 16383, 9, 1000, 3};

  fed_pkg::in_item_t sample_backlog[$];
  fed_pkg::out_item_t echo_expected[$];
  logic in_taken = 1'b0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_settings = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int stall_reqs = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int cycle_count = 0;

  feedback_echo_delay #(.RING_DEPTH(RING_DEPTH)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [15:0] clamp_q15(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic fed_pkg::out_item_t echo_step(input fed_pkg::in_item_t it);
    fed_pkg::out_item_t res;
    int unsigned m;
    int unsigned len;
    int unsigned play;
    int unsigned span;
    longint mix;
    longint acc;
    res = '0;
    if (!it.all_running) return res;
    m = max_delay;
    if (m < 1) m = 1;
    if (m > RING_DEPTH / 2) m = RING_DEPTH / 2;
    len = 2 * m;
    if (len > RING_DEPTH) len = RING_DEPTH;
    play = play_pos % len;
    span = 32'(((longint'(it.delay_control) + 32768) * longint'(m)) >>> 16);
    mix = longint'(echo_mem[play]) + longint'(it.dry_sample);
    echo_mem[(play + span) % len] =
      clamp_q15((mix * (longint'(it.feedback_control) + 32768)) >>> 16);
    acc = longint'(echo_mem[play]) * (longint'(it.blend_control) + 32768)
        + longint'(it.dry_sample) * (32768 - longint'(it.blend_control));
    res.output_sample = clamp_q15(acc >>> 16);
    res.running = 1'b1;
    play_pos = (play + 1) % len;
    return res;
  endfunction

  function automatic fed_pkg::in_item_t mk(input int x, input int d, input int f, input int b,
                                           input bit run);
    fed_pkg::in_item_t it;
    it.dry_sample = 16'(x);
    it.delay_control = 16'(d);
    it.feedback_control = 16'(f);
    it.blend_control = 16'(b);
    it.all_running = run;
    return it;
  endfunction

  function automatic fed_pkg::in_item_t rand_item();
    fed_pkg::in_item_t it;
    it.dry_sample = 16'($urandom);
    case ($urandom_range(7))
      0: it.delay_control = 16'sh8000;
      1: it.delay_control = 16'sh7fff;
      default: it.delay_control = 16'($urandom);
    endcase
    it.feedback_control = ($urandom_range(3) == 0) ? 16'sh7fff : 16'($urandom);
    it.blend_control = 16'($urandom);
    it.all_running = ($urandom_range(9) != 0);
    return it;
  endfunction

  task automatic push_item(input fed_pkg::in_item_t it);
    sample_backlog.push_back(it);
    n_queued++;
  endtask

  task automatic drain_all();
    while (sample_backlog.size() != 0 || n_accepted != n_queued || echo_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_max_delay(input int unsigned v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= fed_pkg::CFG_W'(v);
    max_delay = v & 32'h7fff;
    n_settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= tx_idle) begin
        in_valid <= 1'b1;
        in_data <= sample_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with occasional long hold-off
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_seen != stall_reqs) begin
      stall_seen <= stall_reqs;
      stall_left <= STALL_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    fed_pkg::out_item_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (echo_expected.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected transaction, got sample %0d running %0b",
                 $time, out_data.output_sample, out_data.running);
      end else begin
        want = echo_expected.pop_front();
        if (out_data.output_sample !== want.output_sample) begin
          n_errors++;
          $display("%0t: output_sample expected %0d got %0d",
                   $time, want.output_sample, out_data.output_sample);
        end
        if (out_data.running !== want.running) begin
          n_errors++;
          $display("%0t: running expected %0b got %0b", $time, want.running, out_data.running);
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      echo_expected.push_back(echo_step(in_data));
      n_accepted++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, echo_expected.size());
      $display("feedback_echo_delay verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    tx_idle = 25;
    rx_idle = 77;

    // zero delay, full scale, weights at both ends, stopped sources
    push_item(mk(32767, -32768, 32767, 32767, 1'b1));
    push_item(mk(32767, -32768, 32767, 32767, 1'b1));
    push_item(mk(-32768, -32768, 32767, -32768, 1'b1));
    push_item(mk(-32768, -32768, 32767, 32767, 1'b1));
    push_item(mk(0, 32767, 0, 0, 1'b1));
    push_item(mk(12345, 32767, -32768, 32767, 1'b1));
    push_item(mk(-32768, 0, 32767, -32768, 1'b1));
    push_item(mk(32767, 32767, 32767, 32767, 1'b0));
    push_item(mk(-1, -1, -1, -1, 1'b0));
    push_item(mk(-1, -1, -1, -1, 1'b1));
    push_item(mk(1, 1, 1, 1, 1'b1));
    push_item(mk(-32768, 32767, -32768, -32768, 1'b1));
    push_item(mk(21845, -21846, 16384, -16384, 1'b1));
    push_item(mk(0, -32768, 0, 32767, 1'b1));

    for (int p = 0; p < 13; p++) begin
      if (p == 5) begin
        tx_idle = 77;
        rx_idle = 25;
      end
      if (p == 9) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (p > 0) begin
        drain_all();
        write_max_delay(delay_plan[p-1]);
      end
      repeat (150) push_item(rand_item());
      if (p == 2 || p == 10) stall_reqs++;
    end
    drain_all();
    repeat (20) @(negedge clk);

    $display("Covered %0d samples and %0d results over %0d max delay settings,",
             n_accepted, n_results, n_settings + 1);
    $display("with sender and receiver idling, long output hold-offs and %0d mismatches.",
             n_errors);
    if (n_errors == 0 && echo_expected.size() == 0) begin
      $display("feedback_echo_delay verification clean");
    end else begin
      $display("feedback_echo_delay verification failed");
    end
    $finish;
  end

endmodule
